// ===== rtl/euc_pkg.sv =====
// Package with shared widths, constants and types for the Euclidean spanning tree block.
`timescale 1ns / 1ps
package euc_pkg;
    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int COST_W  = 2 * COORD_BITS + 4;
    localparam int RAD_W   = COST_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int EDGE_W  = 26;
    localparam int TOTAL_W = 32;
    localparam int XYZ_W   = 3 * COORD_BITS;

    // One queue entry: a classified input item.
    typedef struct packed {
        logic                  wr;
        logic [IDX_W-1:0]      addr;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  last;
        logic [CNT_W-1:0]      n;
        logic                  dropped;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0]   vertex;
        logic [IDX_W-1:0]   parent;
        logic               has_parent;
        logic [EDGE_W-1:0]  edge_len;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
        logic               last_edge;
    } t_result;
endpackage

// ===== rtl/euc_front.sv =====
// Front end: counts stored points, flags dropped ones and builds queue entries.
`timescale 1ns / 1ps
module euc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [euc_pkg::COORD_BITS-1:0] i_x,
    input  logic [euc_pkg::COORD_BITS-1:0] i_y,
    input  logic [euc_pkg::COORD_BITS-1:0] i_z,
    input  logic                           i_last,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output euc_pkg::t_job                  o_job
);
    logic [euc_pkg::CNT_W-1:0] r_count;
    logic                      r_dropped;
    logic                      n_room;

    assign n_room   = r_count < euc_pkg::CNT_W'(euc_pkg::MAX_POINTS);
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_job.wr      = n_room;
        o_job.addr    = r_count[euc_pkg::IDX_W-1:0];
        o_job.x       = i_x;
        o_job.y       = i_y;
        o_job.z       = i_z;
        o_job.last    = i_last;
        o_job.n       = n_room ? r_count + 1'b1 : r_count;
        o_job.dropped = r_dropped || !n_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (o_q_push) begin
            if (i_last) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else begin
                r_count   <= o_job.n;
                r_dropped <= o_job.dropped;
            end
        end
    end
endmodule

// ===== rtl/euc_queue.sv =====
// Short queue of classified items between the front end and the tree engine.
`timescale 1ns / 1ps
module euc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  euc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output euc_pkg::t_job o_job
);
    localparam int PTR_W = $clog2(euc_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(euc_pkg::QUEUE_DEPTH + 1);

    euc_pkg::t_job     r_slot [euc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FILL_W-1:0] r_fill;

    assign o_full  = r_fill == FILL_W'(euc_pkg::QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(euc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(euc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_fill <= r_fill + FILL_W'(i_push) - FILL_W'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(euc_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");
endmodule

// ===== rtl/euc_sqrt.sv =====
// Iterative fixed-point square root, one result bit per cycle.
`timescale 1ns / 1ps
module euc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [euc_pkg::COST_W-1:0]  i_d2,
    output logic                        o_done,
    output logic [euc_pkg::ROOT_W-1:0]  o_root
);
    localparam int STEP_W = $clog2(euc_pkg::ROOT_W);

    logic                          r_busy;
    logic [STEP_W-1:0]             r_step;
    logic [euc_pkg::RAD_W-1:0]     r_rad;
    logic [euc_pkg::ROOT_W+1:0]    r_rem;
    logic [euc_pkg::ROOT_W-1:0]    r_root;
    logic [euc_pkg::ROOT_W+3:0]    n_shift;
    logic [euc_pkg::ROOT_W+3:0]    n_trial;
    logic                          n_ge;

    assign n_shift = {r_rem, r_rad[euc_pkg::RAD_W-1 -: 2]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_ge    = n_shift >= n_trial;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rad  <= {i_d2, {(2 * euc_pkg::FRAC_BITS){1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= n_ge ? euc_pkg::ROOT_W'(0) + (euc_pkg::ROOT_W+2)'(n_shift - n_trial)
                               : (euc_pkg::ROOT_W+2)'(n_shift);
                r_root <= {r_root[euc_pkg::ROOT_W-2:0], n_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(euc_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/euc_back.sv =====
// Tree engine: point store, cost table, Prim passes and the result register.
`timescale 1ns / 1ps
module euc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  euc_pkg::t_job    i_job,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output euc_pkg::t_result o_res
);
    localparam int IW = euc_pkg::IDX_W;
    localparam int CW = euc_pkg::CNT_W;
    localparam int KW = euc_pkg::COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_EMIT, S_RDCUR, S_CURCAP, S_PASS, S_SQRT, S_SQWAIT
    } t_state;

    t_state r_state;

    logic [euc_pkg::XYZ_W-1:0]       r_xyz_mem [euc_pkg::MAX_POINTS];
    logic [euc_pkg::COST_W+IW-1:0]   r_cp_mem  [euc_pkg::MAX_POINTS];
    logic [euc_pkg::XYZ_W-1:0]       r_rd_xyz;
    logic [euc_pkg::COST_W+IW-1:0]   r_rd_cp;
    logic [IW-1:0]                   n_rd_addr;

    logic [CW-1:0]                   r_n, r_k, r_i;
    logic [IW-1:0]                   r_cur, r_par;
    logic                            r_drop;
    logic [euc_pkg::EDGE_W-1:0]      r_edge;
    logic [euc_pkg::TOTAL_W-1:0]     r_total;
    logic [euc_pkg::MAX_POINTS-1:0]  r_in_tree;
    logic [euc_pkg::XYZ_W-1:0]       r_cur_xyz;

    logic                            r_v1, r_skip1, r_v2, r_skip2;
    logic [IW-1:0]                   r_i1, r_i2;
    logic [euc_pkg::SQ_W-1:0]        r_sqx, r_sqy, r_sqz;
    logic [euc_pkg::COST_W-1:0]      r_old_cost;
    logic [IW-1:0]                   r_old_par;

    logic                            r_found;
    logic [IW-1:0]                   r_pick, r_pick_par;
    logic [euc_pkg::COST_W-1:0]      r_low;

    logic                            r_out_valid;
    euc_pkg::t_result                r_out;

    logic signed [euc_pkg::DIFF_W-1:0] n_dx, n_dy, n_dz;
    logic [euc_pkg::COST_W-1:0]      n_sum, n_cost;
    logic [IW-1:0]                   n_par;
    logic                            n_upd, n_wr_cp, n_sel, n_pass_done, n_out_free;
    logic                            w_sq_done;
    logic [euc_pkg::ROOT_W-1:0]      w_root;
    logic [euc_pkg::TOTAL_W:0]       n_tot;

    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign n_rd_addr  = (r_state == S_RDCUR) ? r_cur : r_i[IW-1:0];
    assign n_out_free = !r_out_valid || i_pop;
    assign o_empty    = !r_out_valid;
    assign o_res      = r_out;

    // Stage one: coordinate differences against the current vertex.
    assign n_dx = $signed({r_rd_xyz[3*KW-1], r_rd_xyz[3*KW-1 -: KW]})
                - $signed({r_cur_xyz[3*KW-1], r_cur_xyz[3*KW-1 -: KW]});
    assign n_dy = $signed({r_rd_xyz[2*KW-1], r_rd_xyz[2*KW-1 -: KW]})
                - $signed({r_cur_xyz[2*KW-1], r_cur_xyz[2*KW-1 -: KW]});
    assign n_dz = $signed({r_rd_xyz[KW-1], r_rd_xyz[KW-1:0]})
                - $signed({r_cur_xyz[KW-1], r_cur_xyz[KW-1:0]});

    // Stage two: relax the tentative cost and track the running minimum.
    // The first pass writes every entry not yet in the tree, so the table needs no clearing.
    assign n_sum   = euc_pkg::COST_W'(r_sqx) + euc_pkg::COST_W'(r_sqy)
                   + euc_pkg::COST_W'(r_sqz);
    assign n_upd   = (r_k == '0) || (n_sum < r_old_cost);
    assign n_cost  = n_upd ? n_sum : r_old_cost;
    assign n_par   = n_upd ? r_cur : r_old_par;
    assign n_wr_cp = r_v2 && !r_skip2 && n_upd;
    assign n_sel   = r_v2 && !r_skip2 && (!r_found || n_cost < r_low);
    assign n_pass_done = (r_i == r_n) && !r_v1 && !r_v2;
    assign n_tot   = {1'b0, r_total} + (euc_pkg::TOTAL_W+1)'(w_root);

    euc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT),
        .i_d2    (r_low),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_job.wr) begin
            r_xyz_mem[i_job.addr] <= {i_job.x, i_job.y, i_job.z};
        end
        r_rd_xyz <= r_xyz_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_cp) begin
            r_cp_mem[r_i2] <= {n_sum, r_cur};
        end
        r_rd_cp <= r_cp_mem[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_sqx      <= euc_pkg::SQ_W'(n_dx * n_dx);
        r_sqy      <= euc_pkg::SQ_W'(n_dy * n_dy);
        r_sqz      <= euc_pkg::SQ_W'(n_dz * n_dz);
        r_old_cost <= r_rd_cp[euc_pkg::COST_W+IW-1 -: euc_pkg::COST_W];
        r_old_par  <= r_rd_cp[IW-1:0];
        r_i2       <= r_i1;
        r_skip2    <= r_skip1;
        if (n_sel) begin
            r_pick     <= r_i2;
            r_low      <= n_cost;
            r_pick_par <= n_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_in_tree   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_found     <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
            r_n         <= '0;
        end else begin
            if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            r_v2 <= r_v1;
            r_v1 <= 1'b0;
            if (n_sel) begin
                r_found <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_job.last) begin
                        r_n       <= i_job.n;
                        r_drop    <= i_job.dropped;
                        r_k       <= '0;
                        r_cur     <= '0;
                        r_par     <= '0;
                        r_edge    <= '0;
                        r_total   <= '0;
                        r_in_tree <= '0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_out.vertex     <= r_cur;
                        r_out.parent     <= r_par;
                        r_out.has_parent <= r_k != '0;
                        r_out.edge_len   <= r_edge;
                        r_out.total      <= r_total;
                        r_out.overflow   <= r_drop;
                        r_out.last_edge  <= (r_k + 1'b1) == r_n;
                        r_out_valid      <= 1'b1;
                        r_in_tree[r_cur] <= 1'b1;
                        r_state <= ((r_k + 1'b1) == r_n) ? S_IDLE : S_RDCUR;
                    end
                end
                S_RDCUR: begin
                    r_state <= S_CURCAP;
                end
                S_CURCAP: begin
                    r_cur_xyz <= r_rd_xyz;
                    r_i       <= '0;
                    r_found   <= 1'b0;
                    r_state   <= S_PASS;
                end
                S_PASS: begin
                    if (r_i < r_n) begin
                        r_v1    <= 1'b1;
                        r_i1    <= r_i[IW-1:0];
                        r_skip1 <= r_in_tree[r_i[IW-1:0]];
                        r_i     <= r_i + 1'b1;
                    end else if (n_pass_done) begin
                        r_k     <= r_k + 1'b1;
                        r_cur   <= r_pick;
                        r_par   <= r_pick_par;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_state <= S_SQWAIT;
                end
                S_SQWAIT: begin
                    if (w_sq_done) begin
                        r_edge  <= euc_pkg::EDGE_W'(w_root);
                        r_total <= n_tot[euc_pkg::TOTAL_W] ? '1
                                                           : n_tot[euc_pkg::TOTAL_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("pass pipeline stage two without stage one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k < r_n))
        else $error("vertex count ran past the batch size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQWAIT && w_sq_done) |-> r_found)
        else $error("root taken without a picked vertex");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_pop) |=> $stable(r_out))
        else $error("waiting result overwritten");
endmodule

// ===== rtl/euclidean_prim_mst.sv =====
// Top level of the Euclidean minimum spanning tree block (dense Prim's algorithm).
//
//  Channel   Handshake        Payload
//  -------   ---------------  ----------------------------------------------------
//  points    i_push / o_full  i_x_coord, i_y_coord, i_z_coord, i_last_point
//  results   o_empty / i_pop  o_vertex_index, o_parent_index, o_has_parent,
//                             o_edge_length, o_total_length, o_overflow, o_last_edge
//
// Points are classified up front and stored when the engine takes them from a two-entry
// queue. The point marked last starts a run on the N stored points: per tree vertex the
// engine makes one pass over all N cost entries, limited by the single read port of the
// point and cost memories, then a square root step, and then it emits the result and
// fetches the new vertex.
// Reset clears all control state; there is no clearing pass.
// A result that is not popped stalls the engine, and a full queue raises o_full.
`timescale 1ns / 1ps
module euclidean_prim_mst (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [euc_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic [euc_pkg::COORD_BITS-1:0] i_y_coord,
    input  logic [euc_pkg::COORD_BITS-1:0] i_z_coord,
    input  logic                           i_last_point,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [euc_pkg::IDX_W-1:0]      o_vertex_index,
    output logic [euc_pkg::IDX_W-1:0]      o_parent_index,
    output logic                           o_has_parent,
    output logic [euc_pkg::EDGE_W-1:0]     o_edge_length,
    output logic [euc_pkg::TOTAL_W-1:0]    o_total_length,
    output logic                           o_overflow,
    output logic                           o_last_edge
);
    // Queue between front end and engine; the front end only sees its full flag.
    euc_pkg::t_job    w_in_job, w_q_job;
    euc_pkg::t_result w_res;
    logic             w_q_push, w_q_pop, w_q_full, w_q_empty;

    assign o_full = w_q_full;

    euc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_x      (i_x_coord),
        .i_y      (i_y_coord),
        .i_z      (i_z_coord),
        .i_last   (i_last_point),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_job    (w_in_job)
    );

    euc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_in_job),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    // The engine owns the result register, so a waiting result never blocks the queue.
    euc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_job     (w_q_job),
        .o_q_pop   (w_q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (w_res)
    );

    assign o_vertex_index = w_res.vertex;
    assign o_parent_index = w_res.parent;
    assign o_has_parent   = w_res.has_parent;
    assign o_edge_length  = w_res.edge_len;
    assign o_total_length = w_res.total;
    assign o_overflow     = w_res.overflow;
    assign o_last_edge    = w_res.last_edge;
endmodule

// ===== tb/euclidean_prim_mst_tb.sv =====
// Testbench for the Euclidean minimum spanning tree block, checked against its own Prim predictor.
`timescale 1ns / 1ps
module euclidean_prim_mst_tb;
    import euc_pkg::*;

    // The tree predictor keeps its own copy of the point store. When the point
    // marked last is accepted, it grows the whole tree and queues one expected
    // result for every vertex.
    class mst_scoreboard;
        logic signed [COORD_BITS-1:0] px[MAX_POINTS];
        logic signed [COORD_BITS-1:0] py[MAX_POINTS];
        logic signed [COORD_BITS-1:0] pz[MAX_POINTS];
        int      npoints;
        bit      lost_points;
        t_result tree_q[$];
        int      errors;

        function new();
            npoints     = 0;
            lost_points = 0;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function longint unsigned sq_dist(int a, int b);
            longint dx, dy, dz;
            dx = longint'(px[a]) - longint'(px[b]);
            dy = longint'(py[a]) - longint'(py[b]);
            dz = longint'(pz[a]) - longint'(pz[b]);
            return longint'(dx * dx + dy * dy + dz * dz);
        endfunction

        // Integer square root of the squared distance scaled by 4^FRAC_BITS.
        function longint unsigned edge_root(longint unsigned d2);
            longint unsigned scaled, root, trial;
            scaled = d2 << (2 * FRAC_BITS);
            root   = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= scaled) root = trial;
            end
            return root;
        endfunction

        function void note_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                  logic [COORD_BITS-1:0] z, logic last);
            longint unsigned cost[MAX_POINTS];
            int              parent[MAX_POINTS];
            bit              joined[MAX_POINTS];
            longint unsigned seg_len, total, c;
            int              cur, pick;
            t_result         r;
            if (npoints < MAX_POINTS) begin
                px[npoints] = x;
                py[npoints] = y;
                pz[npoints] = z;
                npoints++;
            end else begin
                lost_points = 1;
            end
            if (!last) return;
            for (int i = 0; i < MAX_POINTS; i++) begin
                cost[i]   = 64'hF_FFFF_FFFF;
                parent[i] = 0;
                joined[i] = 0;
            end
            total = 0;
            cur   = 0;
            for (int k = 0; k < npoints; k++) begin
                seg_len = 0;
                if (k > 0) begin
                    // Lowest cost wins; a strict compare keeps the lowest index on ties.
                    pick = -1;
                    for (int i = 0; i < npoints; i++)
                        if (!joined[i] && (pick < 0 || cost[i] < cost[pick])) pick = i;
                    cur     = pick;
                    seg_len = edge_root(cost[cur]);
                    if (seg_len > 64'h3FF_FFFF) seg_len = 64'h3FF_FFFF;
                    total += seg_len;
                    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
                end
                joined[cur]  = 1;
                r.vertex     = IDX_W'(cur);
                r.parent     = (k > 0) ? IDX_W'(parent[cur]) : '0;
                r.has_parent = (k > 0);
                r.edge_len   = EDGE_W'(seg_len);
                r.total      = TOTAL_W'(total);
                r.overflow   = lost_points;
                r.last_edge  = (k + 1 == npoints);
                tree_q.push_back(r);
                for (int i = 0; i < npoints; i++) begin
                    if (!joined[i]) begin
                        c = sq_dist(cur, i);
                        if (c < cost[i]) begin
                            cost[i]   = c;
                            parent[i] = cur;
                        end
                    end
                end
            end
            npoints     = 0;
            lost_points = 0;
        endfunction

        task check_result(t_result got);
            t_result want;
            if (tree_q.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            want = tree_q.pop_front();
            if (got.vertex !== want.vertex)
                report($sformatf("vertex_index %0d, want %0d", got.vertex, want.vertex));
            if (got.parent !== want.parent)
                report($sformatf("parent_index %0d, want %0d", got.parent, want.parent));
            if (got.has_parent !== want.has_parent)
                report($sformatf("has_parent %0b, want %0b", got.has_parent, want.has_parent));
            if (got.edge_len !== want.edge_len)
                report($sformatf("edge_length %0d, want %0d", got.edge_len, want.edge_len));
            if (got.total !== want.total)
                report($sformatf("total_length %0d, want %0d", got.total, want.total));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
            if (got.last_edge !== want.last_edge)
                report($sformatf("last_edge %0b, want %0b", got.last_edge, want.last_edge));
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_push = 0;
    logic                  o_full;
    logic [COORD_BITS-1:0] i_x_coord = '0;
    logic [COORD_BITS-1:0] i_y_coord = '0;
    logic [COORD_BITS-1:0] i_z_coord = '0;
    logic                  i_last_point = 0;
    logic                  o_empty;
    logic                  i_pop = 0;
    logic [IDX_W-1:0]      o_vertex_index;
    logic [IDX_W-1:0]      o_parent_index;
    logic                  o_has_parent;
    logic [EDGE_W-1:0]     o_edge_length;
    logic [TOTAL_W-1:0]    o_total_length;
    logic                  o_overflow;
    logic                  o_last_edge;

    mst_scoreboard tree_sb = new();
    int            send_idle_pct = 0;  // chance per cycle that the sender holds back
    int            pop_stall_pct = 0;  // chance per cycle that the receiver stalls
    int            points_sent = 0;

    euclidean_prim_mst dut (.*);

    always #5 i_clk = ~i_clk;

    // The receiver decides every cycle whether to pop. A result transfer happens
    // at an edge where pop is high and a result is waiting; the values read
    // here are the ones in front of that edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && i_pop && !o_empty) begin
            got.vertex     = o_vertex_index;
            got.parent     = o_parent_index;
            got.has_parent = o_has_parent;
            got.edge_len   = o_edge_length;
            got.total      = o_total_length;
            got.overflow   = o_overflow;
            got.last_edge  = o_last_edge;
            tree_sb.check_result(got);
        end
        i_pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Offers one point and returns after its transfer. Push stays high when the
    // next point follows at once, so it is never dropped and raised in one step.
    task send_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                    logic [COORD_BITS-1:0] z, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 0;
            @(posedge i_clk);
        end
        i_push       <= 1;
        i_x_coord    <= x;
        i_y_coord    <= y;
        i_z_coord    <= z;
        i_last_point <= last;
        do @(posedge i_clk); while (o_full);
        tree_sb.note_point(x, y, z, last);
        points_sent++;
    endtask

    // A batch of n points with the last flag on the final one. A narrow span
    // packs points together so that equal costs and repeated points are common.
    task send_batch(int n, bit narrow);
        logic [COORD_BITS-1:0] c[3];
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++)
                c[a] = narrow ? COORD_BITS'($urandom_range(3)) : COORD_BITS'($urandom);
            send_point(c[0], c[1], c[2], i == n - 1);
        end
    endtask

    // Holds the sender off until every expected result has been transferred.
    task drain();
        i_push <= 0;
        @(posedge i_clk);
        while (tree_sb.tree_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: a lone root, the two far corners of the space, a second pair of far-apart
        // points, a cluster of equal points where ties decide, a line of evenly spaced points and a narrow batch.
        send_point(16'h1234, 16'h8000, 16'h7FFF, 1);
        send_point(16'h8000, 16'h8000, 16'h8000, 0);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
        send_point(16'h7FFF, 16'h8000, 16'h0000, 0);
        send_point(16'h8000, 16'h7FFF, 16'hFFFF, 1);
        for (int i = 0; i < 5; i++) send_point(16'h0005, 16'hFFFB, 16'h0000, i == 4);
        for (int i = 0; i < 6; i++)
            send_point(COORD_BITS'(i * 3), 16'h0000, 16'h0000, i == 5);
        send_batch(4, 1);
        drain();

        // Random batches in four idling phases. The first phase fills the store
        // past capacity so that later points are dropped, the last one among them.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 82; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 82; end
                default: begin send_idle_pct = 6; pop_stall_pct = 6; end
            endcase
            if (phase == 0) send_batch(MAX_POINTS + 2, 0);
            if (phase == 3) send_batch(MAX_POINTS, 0);
            while (points_sent < 100 + 60 * phase + (phase == 3 ? 60 : 0))
                send_batch($urandom_range(8, 1), $urandom_range(2) == 0);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (tree_sb.tree_q.size() != 0)
            tree_sb.report($sformatf("%0d results never arrived", tree_sb.tree_q.size()));
        if (tree_sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== euclidean_prim_mst.f =====
rtl/euc_pkg.sv
rtl/euc_front.sv
rtl/euc_queue.sv
rtl/euc_sqrt.sv
rtl/euc_back.sv
rtl/euclidean_prim_mst.sv
tb/euclidean_prim_mst_tb.sv
